// ===== hdl/sat_polygon_polygon_collision_core_macros.svh =====
// Assertion macros used by the checker of the collision core.
// Depends on nothing; files that assert take it by include.
`ifndef SAT_POLYGON_POLYGON_COLLISION_CORE_MACROS_SVH
`define SAT_POLYGON_POLYGON_COLLISION_CORE_MACROS_SVH

// Clocked assertion, disabled during reset.
`define SATPP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define SATPP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/satpp_pkg.sv =====
// Package of the polygon collision core: state, command and status types.
// Used by the controller, the datapath and the top level.
package satpp_pkg;

  localparam int DEF_MAX_VERTS = 16;

  localparam int ROOT_STEPS = 32;
  localparam int DIV_STEPS  = 17;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_RD_I, ST_RD_J, ST_DIFF, ST_NORM, ST_SQX, ST_SQY,
    ST_ROOT, ST_DIVI, ST_DIV, ST_AXIS, ST_PRD, ST_PMUL, ST_PACC, ST_CHECK,
    ST_NEXT, ST_FLIPM, ST_FLIPA, ST_SCM, ST_SCF, ST_MISS, ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_INIT, OP_RD_I, OP_RD_J, OP_DIFF, OP_NORM, OP_SQX, OP_SQY,
    OP_ROOT, OP_DIVI, OP_DIV, OP_AXIS, OP_PRD, OP_PMUL, OP_PACC, OP_CHECK,
    OP_NEXT, OP_FLIPM, OP_FLIPA, OP_SCM, OP_SCF, OP_MISS, OP_EMIT
  } dp_op_t;

  typedef enum logic [1:0] {
    MODE_VERT_A   = 2'd0,
    MODE_VERT_B   = 2'd1,
    MODE_CENTRE_A = 2'd2,
    MODE_CENTRE_B = 2'd3
  } mode_t;

  typedef struct packed {
    dp_op_t op;
    logic   load;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic edge_zero;
    logic root_last;
    logic len_zero;
    logic div_last;
    logic proj_last;
    logic sep;
    logic edges_last;
    logic have;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== hdl/satpp_ctrl.sv =====
// Controller of the polygon collision core: sequences loading and the axis test.
// Depends on satpp_pkg; drives the datapath by command and reads its status.
module satpp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_last,
  output logic               in_ready,
  input  satpp_pkg::dp_sts_t sts,
  output satpp_pkg::dp_cmd_t cmd
);

  satpp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= satpp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      satpp_pkg::ST_IDLE:  if (in_valid && in_last) state_next = satpp_pkg::ST_START;
      satpp_pkg::ST_START: state_next = sts.empty ? satpp_pkg::ST_MISS : satpp_pkg::ST_RD_I;
      satpp_pkg::ST_RD_I:  state_next = satpp_pkg::ST_RD_J;
      satpp_pkg::ST_RD_J:  state_next = satpp_pkg::ST_DIFF;
      satpp_pkg::ST_DIFF:  state_next = satpp_pkg::ST_NORM;
      satpp_pkg::ST_NORM:  state_next = sts.edge_zero ? satpp_pkg::ST_NEXT : satpp_pkg::ST_SQX;
      satpp_pkg::ST_SQX:   state_next = satpp_pkg::ST_SQY;
      satpp_pkg::ST_SQY:   state_next = satpp_pkg::ST_ROOT;
      satpp_pkg::ST_ROOT:  if (sts.root_last) state_next = satpp_pkg::ST_DIVI;
      satpp_pkg::ST_DIVI:  state_next = sts.len_zero ? satpp_pkg::ST_NEXT : satpp_pkg::ST_DIV;
      satpp_pkg::ST_DIV:   if (sts.div_last) state_next = satpp_pkg::ST_AXIS;
      satpp_pkg::ST_AXIS:  state_next = satpp_pkg::ST_PRD;
      satpp_pkg::ST_PRD:   state_next = satpp_pkg::ST_PMUL;
      satpp_pkg::ST_PMUL:  state_next = satpp_pkg::ST_PACC;
      satpp_pkg::ST_PACC:  state_next = sts.proj_last ? satpp_pkg::ST_CHECK : satpp_pkg::ST_PRD;
      satpp_pkg::ST_CHECK: state_next = sts.sep ? satpp_pkg::ST_MISS : satpp_pkg::ST_NEXT;
      satpp_pkg::ST_NEXT:  state_next = sts.edges_last ? satpp_pkg::ST_FLIPM : satpp_pkg::ST_RD_I;
      satpp_pkg::ST_FLIPM: state_next = sts.have ? satpp_pkg::ST_FLIPA : satpp_pkg::ST_MISS;
      satpp_pkg::ST_FLIPA: state_next = satpp_pkg::ST_SCM;
      satpp_pkg::ST_SCM:   state_next = satpp_pkg::ST_SCF;
      satpp_pkg::ST_SCF:   state_next = satpp_pkg::ST_OUT;
      satpp_pkg::ST_MISS:  state_next = satpp_pkg::ST_OUT;
      satpp_pkg::ST_OUT:   if (sts.out_free) state_next = satpp_pkg::ST_IDLE;
      default:             state_next = satpp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == satpp_pkg::ST_IDLE);
    cmd.load = in_valid && (state == satpp_pkg::ST_IDLE);
    unique case (state)
      satpp_pkg::ST_START: cmd.op = satpp_pkg::OP_INIT;
      satpp_pkg::ST_RD_I:  cmd.op = satpp_pkg::OP_RD_I;
      satpp_pkg::ST_RD_J:  cmd.op = satpp_pkg::OP_RD_J;
      satpp_pkg::ST_DIFF:  cmd.op = satpp_pkg::OP_DIFF;
      satpp_pkg::ST_NORM:  cmd.op = satpp_pkg::OP_NORM;
      satpp_pkg::ST_SQX:   cmd.op = satpp_pkg::OP_SQX;
      satpp_pkg::ST_SQY:   cmd.op = satpp_pkg::OP_SQY;
      satpp_pkg::ST_ROOT:  cmd.op = satpp_pkg::OP_ROOT;
      satpp_pkg::ST_DIVI:  cmd.op = satpp_pkg::OP_DIVI;
      satpp_pkg::ST_DIV:   cmd.op = satpp_pkg::OP_DIV;
      satpp_pkg::ST_AXIS:  cmd.op = satpp_pkg::OP_AXIS;
      satpp_pkg::ST_PRD:   cmd.op = satpp_pkg::OP_PRD;
      satpp_pkg::ST_PMUL:  cmd.op = satpp_pkg::OP_PMUL;
      satpp_pkg::ST_PACC:  cmd.op = satpp_pkg::OP_PACC;
      satpp_pkg::ST_CHECK: cmd.op = satpp_pkg::OP_CHECK;
      satpp_pkg::ST_NEXT:  cmd.op = satpp_pkg::OP_NEXT;
      satpp_pkg::ST_FLIPM: cmd.op = satpp_pkg::OP_FLIPM;
      satpp_pkg::ST_FLIPA: cmd.op = satpp_pkg::OP_FLIPA;
      satpp_pkg::ST_SCM:   cmd.op = satpp_pkg::OP_SCM;
      satpp_pkg::ST_SCF:   cmd.op = satpp_pkg::OP_SCF;
      satpp_pkg::ST_MISS:  cmd.op = satpp_pkg::OP_MISS;
      satpp_pkg::ST_OUT:   cmd.op = sts.out_free ? satpp_pkg::OP_EMIT : satpp_pkg::OP_NOP;
      default:             cmd.op = satpp_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== hdl/satpp_dp.sv =====
// Datapath of the polygon collision core: vertex stores, root, divider,
// projection, depth tracking and the output register. Depends on satpp_pkg.
module satpp_dp #(
  parameter int MAX_VERTS = satpp_pkg::DEF_MAX_VERTS
) (
  input  logic               clk,
  input  logic               rst,
  input  satpp_pkg::dp_cmd_t cmd,
  output satpp_pkg::dp_sts_t sts,
  input  logic [1:0]         in_mode,
  input  logic [31:0]        in_x,
  input  logic [31:0]        in_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_collided,
  output logic [31:0]        out_mtv_x,
  output logic [31:0]        out_mtv_y,
  output logic               out_status
);

  localparam int AW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);

  logic [63:0] mem_a [MAX_VERTS];
  logic [63:0] mem_b [MAX_VERTS];
  logic [63:0] rdata_a, rdata_b;
  logic [AW-1:0] raddr;

  logic [CW-1:0] cnt_a, cnt_b;
  logic          ovf;
  logic signed [31:0] cax, cay, cbx, cby;

  logic [CW-1:0] i, k;
  logic          p, pp;
  logic [4:0]    step;

  logic signed [31:0] pi_x, pi_y;
  logic [31:0] magx, magy;
  logic        sgnx, sgny;
  logic [29:0] mx, my;
  logic [59:0] sq;
  logic [63:0] rv, res, rbit;
  logic [30:0] len;
  logic [46:0] nregx, nregy;
  logic [30:0] rx, ry;
  logic [16:0] qx, qy;
  logic signed [17:0] ux, uy, bx, by;
  logic signed [49:0] px, py;
  logic signed [50:0] min_a, max_a, min_b, max_b;
  logic signed [51:0] best;
  logic        have;
  logic signed [50:0] fx, fy;
  logic [52:0] mprod_x, mprod_y;
  logic        neg_x, neg_y;
  logic        res_hit;
  logic [31:0] res_x, res_y;

  logic [CW-1:0] cur_cnt, proj_cnt, i_inc, j;
  logic [63:0]   edge_pt, proj_pt;
  logic signed [32:0] ex, ey;
  logic [31:0] big;
  logic [63:0] root_try;
  logic [46:0] numx, numy;
  logic [31:0] tx, ty;
  logic        gex, gey;
  logic signed [50:0] pv;
  logic signed [51:0] da, db, depth;
  logic signed [32:0] dcx, dcy;
  logic signed [51:0] dir;
  logic signed [51:0] dsum;
  logic [17:0] babs_x, babs_y;
  logic [53:0] mr_x, mr_y;
  logic [37:0] m_x, m_y;
  logic [31:0] sat_x, sat_y;

  assign cur_cnt  = p ? cnt_b : cnt_a;
  assign proj_cnt = pp ? cnt_b : cnt_a;
  assign i_inc    = i + CW'(1);
  assign j        = (i_inc == cur_cnt) ? '0 : i_inc;
  assign edge_pt  = p ? rdata_b : rdata_a;
  assign proj_pt  = pp ? rdata_b : rdata_a;

  always_comb begin
    case (cmd.op)
      satpp_pkg::OP_RD_I: raddr = i[AW-1:0];
      satpp_pkg::OP_RD_J: raddr = j[AW-1:0];
      default:            raddr = k[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_mode == satpp_pkg::MODE_VERT_A && cnt_a < CW'(MAX_VERTS)) begin
      mem_a[cnt_a[AW-1:0]] <= {in_y, in_x};
    end
    if (cmd.load && in_mode == satpp_pkg::MODE_VERT_B && cnt_b < CW'(MAX_VERTS)) begin
      mem_b[cnt_b[AW-1:0]] <= {in_y, in_x};
    end
    rdata_a <= mem_a[raddr];
    rdata_b <= mem_b[raddr];
  end

  assign ex = 33'(signed'(edge_pt[31:0])) - 33'(pi_x);
  assign ey = 33'(signed'(edge_pt[63:32])) - 33'(pi_y);
  assign big = (magx > magy) ? magx : magy;
  assign root_try = res + rbit;
  assign numx = {1'b0, mx, 16'b0} + {17'b0, res[30:1]};
  assign numy = {1'b0, my, 16'b0} + {17'b0, res[30:1]};
  assign tx = {rx, nregx[16]};
  assign ty = {ry, nregy[16]};
  assign gex = (tx >= {1'b0, len});
  assign gey = (ty >= {1'b0, len});
  assign pv = 51'(px) + 51'(py);
  assign da = 52'(max_b) - 52'(min_a);
  assign db = 52'(max_a) - 52'(min_b);
  assign depth = (da < db) ? da : db;
  assign dcx = 33'(cbx) - 33'(cax);
  assign dcy = 33'(cby) - 33'(cay);
  assign dir = 52'(fx) + 52'(fy);
  assign dsum = best + 52'sd32768;
  assign babs_x = bx[17] ? 18'(-bx) : 18'(bx);
  assign babs_y = by[17] ? 18'(-by) : 18'(by);
  assign mr_x = 54'(mprod_x) + 54'd32768;
  assign mr_y = 54'(mprod_y) + 54'd32768;
  assign m_x = mr_x[53:16];
  assign m_y = mr_y[53:16];

  always_comb begin
    if (neg_x) begin
      sat_x = (m_x > 38'h80000000) ? 32'h80000000 : 32'(32'd0 - m_x[31:0]);
    end else begin
      sat_x = (m_x > 38'h7FFFFFFF) ? 32'h7FFFFFFF : m_x[31:0];
    end
    if (neg_y) begin
      sat_y = (m_y > 38'h80000000) ? 32'h80000000 : 32'(32'd0 - m_y[31:0]);
    end else begin
      sat_y = (m_y > 38'h7FFFFFFF) ? 32'h7FFFFFFF : m_y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_a     <= '0;
      cnt_b     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == satpp_pkg::OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.op == satpp_pkg::OP_EMIT) begin
        cnt_a     <= '0;
        cnt_b     <= '0;
        ovf       <= 1'b0;
      end else if (cmd.load) begin
        if (in_mode == satpp_pkg::MODE_VERT_A) begin
          if (cnt_a < CW'(MAX_VERTS)) cnt_a <= cnt_a + CW'(1);
          else ovf <= 1'b1;
        end else if (in_mode == satpp_pkg::MODE_VERT_B) begin
          if (cnt_b < CW'(MAX_VERTS)) cnt_b <= cnt_b + CW'(1);
          else ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && in_mode == satpp_pkg::MODE_CENTRE_A) begin
      cax <= in_x;
      cay <= in_y;
    end
    if (cmd.load && in_mode == satpp_pkg::MODE_CENTRE_B) begin
      cbx <= in_x;
      cby <= in_y;
    end
    if (cmd.op == satpp_pkg::OP_EMIT) begin
      out_collided <= res_hit;
      out_mtv_x    <= res_x;
      out_mtv_y    <= res_y;
      out_status   <= ovf;
    end
    case (cmd.op)
      satpp_pkg::OP_INIT: begin
        i    <= '0;
        p    <= 1'b0;
        have <= 1'b0;
      end
      satpp_pkg::OP_RD_J: begin
        pi_x <= edge_pt[31:0];
        pi_y <= edge_pt[63:32];
      end
      satpp_pkg::OP_DIFF: begin
        // The normal is (-ey, ex).
        magx <= ey[32] ? 32'(-ey) : ey[31:0];
        sgnx <= !ey[32] && (ey != '0);
        magy <= ex[32] ? 32'(-ex) : ex[31:0];
        sgny <= ex[32];
      end
      satpp_pkg::OP_NORM: begin
        if (big[31]) begin
          mx <= magx[31:2];
          my <= magy[31:2];
        end else if (big[30]) begin
          mx <= magx[30:1];
          my <= magy[30:1];
        end else begin
          mx <= magx[29:0];
          my <= magy[29:0];
        end
      end
      satpp_pkg::OP_SQX: sq <= mx * mx;
      satpp_pkg::OP_SQY: begin
        rv   <= 64'(sq) + 64'(my * my);
        res  <= '0;
        rbit <= 64'h4000_0000_0000_0000;
        step <= '0;
      end
      satpp_pkg::OP_ROOT: begin
        if (rv >= root_try) begin
          rv  <= rv - root_try;
          res <= (res >> 1) + rbit;
        end else begin
          res <= res >> 1;
        end
        rbit <= rbit >> 2;
        step <= step + 5'd1;
      end
      satpp_pkg::OP_DIVI: begin
        len   <= res[30:0];
        nregx <= numx;
        nregy <= numy;
        rx    <= {1'b0, numx[46:17]};
        ry    <= {1'b0, numy[46:17]};
        qx    <= '0;
        qy    <= '0;
        step  <= '0;
      end
      satpp_pkg::OP_DIV: begin
        rx    <= gex ? 31'(tx - {1'b0, len}) : tx[30:0];
        ry    <= gey ? 31'(ty - {1'b0, len}) : ty[30:0];
        qx    <= {qx[15:0], gex};
        qy    <= {qy[15:0], gey};
        nregx <= nregx << 1;
        nregy <= nregy << 1;
        step  <= step + 5'd1;
      end
      satpp_pkg::OP_AXIS: begin
        ux <= sgnx ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
        uy <= sgny ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
        k  <= '0;
        pp <= 1'b0;
      end
      satpp_pkg::OP_PMUL: begin
        px <= signed'(proj_pt[31:0]) * ux;
        py <= signed'(proj_pt[63:32]) * uy;
      end
      satpp_pkg::OP_PACC: begin
        if (!pp) begin
          if (k == '0 || pv < min_a) min_a <= pv;
          if (k == '0 || pv > max_a) max_a <= pv;
        end else begin
          if (k == '0 || pv < min_b) min_b <= pv;
          if (k == '0 || pv > max_b) max_b <= pv;
        end
        if (k == proj_cnt - CW'(1)) begin
          k  <= '0;
          pp <= 1'b1;
        end else begin
          k <= k + CW'(1);
        end
      end
      satpp_pkg::OP_CHECK: begin
        if (!have || depth < best) begin
          have <= 1'b1;
          best <= depth;
          bx   <= ux;
          by   <= uy;
        end
      end
      satpp_pkg::OP_NEXT: begin
        if (i == cur_cnt - CW'(1)) begin
          i <= '0;
          p <= 1'b1;
        end else begin
          i <= i_inc;
        end
      end
      satpp_pkg::OP_FLIPM: begin
        fx <= dcx * bx;
        fy <= dcy * by;
      end
      satpp_pkg::OP_FLIPA: begin
        if (dir > 52'sd0) begin
          bx <= -bx;
          by <= -by;
        end
      end
      satpp_pkg::OP_SCM: begin
        mprod_x <= dsum[51:16] * babs_x[16:0];
        mprod_y <= dsum[51:16] * babs_y[16:0];
        neg_x   <= bx[17];
        neg_y   <= by[17];
      end
      satpp_pkg::OP_SCF: begin
        res_hit <= 1'b1;
        res_x   <= sat_x;
        res_y   <= sat_y;
      end
      satpp_pkg::OP_MISS: begin
        res_hit <= 1'b0;
        res_x   <= '0;
        res_y   <= '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.empty      = (cnt_a == '0) || (cnt_b == '0);
    sts.edge_zero  = (magx == '0) && (magy == '0);
    sts.root_last  = (step == 5'(satpp_pkg::ROOT_STEPS - 1));
    sts.len_zero   = (res[30:0] == '0);
    sts.div_last   = (step == 5'(satpp_pkg::DIV_STEPS - 1));
    sts.proj_last  = pp && (k == cnt_b - CW'(1));
    sts.sep        = (min_a >= max_b) || (min_b >= max_a);
    sts.edges_last = p && (i == cnt_b - CW'(1));
    sts.have       = have;
    sts.out_free   = !out_valid || out_ready;
  end

endmodule

// ===== hdl/sat_polygon_polygon_collision_core.sv =====
// Separating-axis collision core for two convex polygons, Q16.16 coordinates.
// Loading items are taken one per cycle while the core is idle. A test runs, per edge,
// the 32-step root, the 17-step divider and a projection that reads each vertex of
// both polygons in turn through the store read port. No item is taken during a test.
// Reset clears the counts, the overflow flag and the output valid flag; vertex stores
// and centers stay undefined until written.
module sat_polygon_polygon_collision_core #(
  parameter int MAX_VERTS = satpp_pkg::DEF_MAX_VERTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // coord_x, coord_y
  input  logic [1:0]  s_tuser,   // mode
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // collided, mtv_x, mtv_y, zero fill
  output logic        m_tuser    // status
);

  satpp_pkg::dp_cmd_t cmd;
  satpp_pkg::dp_sts_t sts;
  logic        collided;
  logic [31:0] mtv_x, mtv_y;

  satpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  satpp_dp #(.MAX_VERTS(MAX_VERTS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_mode      (s_tuser),
    .in_x         (s_tdata[31:0]),
    .in_y         (s_tdata[63:32]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_collided (collided),
    .out_mtv_x    (mtv_x),
    .out_mtv_y    (mtv_y),
    .out_status   (m_tuser)
  );

  assign m_tdata = {7'b0, mtv_y, mtv_x, collided};

endmodule

// ===== hdl/satpp_chk.sv =====
// Port-level checker for the polygon collision core, bound to the top level.
// Depends on the assertion macros header.
`include "sat_polygon_polygon_collision_core_macros.svh"

module satpp_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [63:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tuser
);

  `SATPP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `SATPP_ASSERT(a_miss_zero, m_tvalid && !m_tdata[0] |-> m_tdata[64:1] == 64'd0, "nonzero vector without collision")
  `SATPP_ASSERT(a_test_busy, s_tvalid && s_tready && s_tlast |=> !s_tready, "input taken after a last transfer")
  `SATPP_ASSERT_ALWAYS(a_fill_zero, m_tdata[71:65] == 7'd0, "fill bits of result not zero")

endmodule

bind sat_polygon_polygon_collision_core satpp_chk u_satpp_chk (.*);
